[hdl/bpts_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpts_pkg
// shared constants, beat types and controller types for the bitmap scheduler
// ----------------------------------------------------------------------------
package bpts_pkg;

	localparam int NUM_PRIO   = 32;
	localparam int PRIO_BITS  = $clog2(NUM_PRIO);
	localparam int DELAY_BITS = 16;
	localparam int LOCK_BITS  = 8;
	localparam int MASK_BITS  = 32;
	localparam int AMT_BITS   = 16;

	localparam logic [LOCK_BITS-1:0]  LOCK_MAX  = 8'd255;
	localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

	localparam logic [2:0] OP_START  = 3'd0;
	localparam logic [2:0] OP_TICK   = 3'd1;
	localparam logic [2:0] OP_DELAY  = 3'd2;
	localparam logic [2:0] OP_LOCK   = 3'd3;
	localparam logic [2:0] OP_UNLOCK = 3'd4;

	typedef struct packed {
		logic [2:0]          opcode;
		logic [AMT_BITS-1:0] delay_amount;
	} event_t;

	typedef struct packed {
		logic                 switch_now;
		logic [4:0]           running_prio;
		logic [MASK_BITS-1:0] ready_bits;
		logic [LOCK_BITS-1:0] lock_depth;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_PICK
	} state_t;

	typedef struct packed {
		logic load;
		logic exec;
		logic commit;
	} cmd_t;

endpackage

`default_nettype wire

[hdl/bpts_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpts_datapath
// task state: ready bitmap, per-slot delay counters, lock count, selection
// ----------------------------------------------------------------------------
module bpts_datapath (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire bpts_pkg::cmd_t                    cmd,
	input  wire bpts_pkg::event_t                  event_beat,
	input  wire logic                              cfg_we,
	input  wire logic [bpts_pkg::MASK_BITS-1:0]    cfg_wdata,
	output bpts_pkg::result_t                      result_beat
);

	logic [bpts_pkg::NUM_PRIO-1:0]   present_q;
	logic [bpts_pkg::NUM_PRIO-1:0]   ready_q;
	logic [bpts_pkg::DELAY_BITS-1:0] delay_q [bpts_pkg::NUM_PRIO];
	logic [bpts_pkg::PRIO_BITS-1:0]  current_q;
	logic [bpts_pkg::LOCK_BITS-1:0]  lock_q;
	bpts_pkg::event_t                ev_q;
	logic                            pick_en_q;
	bpts_pkg::result_t               result_q;

	logic [bpts_pkg::PRIO_BITS-1:0]  top_idx;
	logic                            top_found;
	logic                            do_switch;
	logic [bpts_pkg::DELAY_BITS-1:0] amt_sat;

	// priority encoder, lowest slot wins
	always_comb begin
		top_idx   = '0;
		top_found = 1'b0;
		for (int i = bpts_pkg::NUM_PRIO - 1; i >= 0; i--) begin
			if (ready_q[i]) begin
				top_idx   = bpts_pkg::PRIO_BITS'(i);
				top_found = 1'b1;
			end
		end
	end

	assign do_switch = pick_en_q && top_found && (top_idx != current_q);

	assign amt_sat = (32'(ev_q.delay_amount) > 32'(bpts_pkg::DELAY_MAX))
		? bpts_pkg::DELAY_MAX : bpts_pkg::DELAY_BITS'(ev_q.delay_amount);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ev_q <= event_beat;
		end
		if (cmd.commit) begin
			result_q.switch_now   <= do_switch;
			result_q.running_prio <= 5'(do_switch ? top_idx : current_q);
			result_q.ready_bits   <= bpts_pkg::MASK_BITS'(ready_q);
			result_q.lock_depth   <= lock_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			ready_q   <= '0;
			current_q <= '0;
			lock_q    <= '0;
			pick_en_q <= 1'b0;
			for (int i = 0; i < bpts_pkg::NUM_PRIO; i++) begin
				delay_q[i] <= '0;
			end
		end else begin
			if (cfg_we) begin
				present_q <= bpts_pkg::NUM_PRIO'(cfg_wdata);
				ready_q   <= ready_q & bpts_pkg::NUM_PRIO'(cfg_wdata);
			end
			if (cmd.exec) begin
				case (ev_q.opcode)
					bpts_pkg::OP_START: begin
						ready_q   <= present_q;
						pick_en_q <= 1'b1;
						for (int i = 0; i < bpts_pkg::NUM_PRIO; i++) begin
							delay_q[i] <= '0;
						end
					end
					bpts_pkg::OP_TICK: begin
						pick_en_q <= (lock_q == '0);
						for (int i = 0; i < bpts_pkg::NUM_PRIO; i++) begin
							if (present_q[i]) begin
								if (delay_q[i] != '0) begin
									delay_q[i] <= delay_q[i] - 1'b1;
								end else begin
									ready_q[i] <= 1'b1;
								end
							end
						end
					end
					bpts_pkg::OP_DELAY: begin
						delay_q[current_q] <= amt_sat;
						ready_q[current_q] <= 1'b0;
						pick_en_q          <= (lock_q == '0);
					end
					bpts_pkg::OP_LOCK: begin
						pick_en_q <= 1'b0;
						if (lock_q != bpts_pkg::LOCK_MAX) begin
							lock_q <= lock_q + 1'b1;
						end
					end
					bpts_pkg::OP_UNLOCK: begin
						pick_en_q <= (lock_q == bpts_pkg::LOCK_BITS'(1));
						if (lock_q != '0) begin
							lock_q <= lock_q - 1'b1;
						end
					end
					default: begin
						pick_en_q <= 1'b0;
					end
				endcase
			end
			if (cmd.commit && do_switch) begin
				current_q <= top_idx;
			end
		end
	end

	assign result_beat = result_q;

endmodule

`default_nettype wire

[hdl/bpts_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bpts_ctrl
// sequencer: accept beat, execute opcode, select and load the result register
// ----------------------------------------------------------------------------
module bpts_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           event_valid,
	output logic                event_stall,
	output logic                result_valid,
	input  wire logic           result_stall,
	output bpts_pkg::cmd_t      cmd
);

	bpts_pkg::state_t state_q;
	bpts_pkg::state_t state_nxt;
	logic             out_valid_q;
	logic             out_free;

	assign out_free = !out_valid_q || !result_stall;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			bpts_pkg::ST_IDLE: begin
				if (event_valid) begin
					state_nxt = bpts_pkg::ST_EXEC;
				end
			end
			bpts_pkg::ST_EXEC: begin
				state_nxt = bpts_pkg::ST_PICK;
			end
			bpts_pkg::ST_PICK: begin
				if (out_free) begin
					state_nxt = bpts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = bpts_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		event_stall = 1'b1;
		cmd         = '0;
		case (state_q)
			bpts_pkg::ST_IDLE: begin
				event_stall = 1'b0;
				cmd.load    = event_valid;
			end
			bpts_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
			end
			bpts_pkg::ST_PICK: begin
				cmd.commit = out_free;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bpts_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!result_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = out_valid_q;

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(event_valid && !event_stall) |=> (state_q == bpts_pkg::ST_EXEC))
		else $error("accepted beat did not enter execute");

	a_commit_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> result_valid)
		else $error("commit did not present a result");

	a_out_rise_after_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(cmd.commit))
		else $error("result appeared without a commit");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || !result_stall))
		else $error("commit overwrote a stalled result");

endmodule

`default_nettype wire

[hdl/bitmap_priority_task_scheduler.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// bitmap_priority_task_scheduler
// priority bitmap task scheduler with tick delays and scheduler lock
// ----------------------------------------------------------------------------
// an accepted event passes execute, then select, which loads the out register
// select waits on a stalled out register; one event is processed at a time
// a new event is taken while the previous result still waits in the out register
// reset: asynchronous, clears mask, ready bits, delay counters, lock count, slot 0
// ----------------------------------------------------------------------------
module bitmap_priority_task_scheduler (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bpts_pkg::MASK_BITS-1:0]  cfg_wdata,
	input  wire logic                            event_valid,
	output logic                                 event_stall,
	input  wire bpts_pkg::event_t                event_beat,
	output logic                                 result_valid,
	input  wire logic                            result_stall,
	output bpts_pkg::result_t                    result_beat
);

	bpts_pkg::cmd_t cmd;

	bpts_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.event_valid  (event_valid),
		.event_stall  (event_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.cmd          (cmd)
	);

	bpts_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.event_beat  (event_beat),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.result_beat (result_beat)
	);

endmodule

`default_nettype wire
